// File: src/eaq_pkg.sv
// Package: shared types and constants for the Euler-angle to quaternion converter.
`timescale 1ns / 1ps
package eaq_pkg;
  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [34:0] DEG_TO_RAD_Q40 = 35'((PI_Q60 / 64'd180 + 64'd524288) >> 20);
  // floor(h / 45) = (h * RECIP45) >> RECIP_SH, exact for h < 2^21
  localparam logic [21:0] RECIP45 = 22'd2982617;
  localparam int RECIP_SH = 27;

  typedef logic [29:0] atan_t;

  function automatic atan_t atan_q30(input logic [4:0] i);
    atan_t v;
    case (i)
      5'd0: v = 30'd843314857;
      5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043837;
      5'd3: v = 30'd133525159;
      5'd4: v = 30'd67021687;
      5'd5: v = 30'd33543516;
      5'd6: v = 30'd16775851;
      5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194283;
      5'd9: v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd31: v = 30'd0;
      default: v = 30'(32'd1 << (5'd30 - i));
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic neg_sin;
    logic neg_cos;
  } sign_t;
endpackage

// File: src/eaq_sincos.sv
// Pipelined half-angle sine/cosine: range reduction, radian scaling, unrolled CORDIC.
`timescale 1ns / 1ps
module eaq_sincos
  import eaq_pkg::*;
#(
  parameter int CORDIC_STEPS = 24,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [23:0]  angle,
  output logic signed [31:0]  sin_q,
  output logic signed [31:0]  cos_q
);
  localparam int UNIT = 1 << (ANGLE_FRAC_BITS + 1);
  localparam int FULL_I = 360 * UNIT;
  localparam int HALF_I = 180 * UNIT;
  localparam int NSH = ANGLE_FRAC_BITS + 4;  // full turn = 45 << NSH
  localparam int M_TURNS = (8388608 + FULL_I - 1) / FULL_I;
  localparam logic [27:0] BIAS = 28'(HALF_I + M_TURNS * FULL_I);
  localparam logic signed [34:0] HALF = 35'(HALF_I);
  localparam logic signed [34:0] QUART = 35'(90 * UNIT);
  localparam int NS = CORDIC_STEPS;
  localparam int SH = 11 + ANGLE_FRAC_BITS;

  // stage 1: bias to nonnegative, turn count by reciprocal multiply
  logic signed [27:0] a_ext;
  logic [27:0] u;
  logic [20:0] h;
  logic [27:0] u_r;
  logic [42:0] qm_r;

  assign a_ext = 28'(angle);
  assign u = $unsigned(a_ext) + BIAS;
  assign h = 21'(u >> NSH);

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u;
      qm_r <= 43'(h) * 43'(RECIP45);
    end
  end

  // stage 2: remainder in [-180, 180), fold to [-90, 90], magnitude
  logic [15:0] k;
  logic signed [34:0] r0, r1;
  sign_t sg_nxt, sg_r;
  logic [23:0] mag_r;
  logic [58:0] prod_r;
  sign_t sg2_r;

  assign k = 16'(qm_r >> RECIP_SH);

  always_comb begin
    r0 = $signed(35'(u_r) - 35'(k) * 35'(FULL_I) - 35'(HALF_I));
    r1 = r0;
    sg_nxt = '0;
    if (r1 > QUART) begin
      r1 = HALF - r1;
      sg_nxt.neg_cos = 1'b1;
    end else if (r1 < -QUART) begin
      r1 = -HALF - r1;
      sg_nxt.neg_cos = 1'b1;
    end
    if (r1 < 0) begin
      r1 = -r1;
      sg_nxt.neg_sin = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r <= sg_nxt;
      mag_r <= 24'(r1);
      sg2_r <= sg_r;
      prod_r <= 59'(mag_r) * 59'(DEG_TO_RAD_Q40);
    end
  end

  logic signed [35:0] z0;
  assign z0 = 36'((prod_r + (59'd1 << (SH - 1))) >> SH);

  logic signed [35:0] x_r [NS+1];
  logic signed [35:0] y_r [NS+1];
  logic signed [35:0] z_r [NS+1];
  sign_t s_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= z0;
      s_r[0] <= sg2_r;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [35:0] dx, dy, at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = 36'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1] <= s_r[i];
        if (!z_r[i][35]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  logic signed [35:0] xc, yc;
  always_comb begin
    xc = x_r[NS];
    if (xc > ONE_Q30) xc = ONE_Q30;
    else if (xc < -ONE_Q30) xc = -ONE_Q30;
    yc = y_r[NS];
    if (yc > ONE_Q30) yc = ONE_Q30;
    else if (yc < -ONE_Q30) yc = -ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= 32'(s_r[NS].neg_cos ? -xc : xc);
      sin_q <= 32'(s_r[NS].neg_sin ? -yc : yc);
    end
  end
endmodule

// File: src/euler_angles_to_quaternion.sv
// Top level: Euler angles (degrees) to quaternion, fully pipelined.
//  channel | dir | fields
//  in_     | in  | tdata: pitch_deg[23:0], yaw_deg[47:24], roll_deg[71:48]
//  out_    | out | tdata: quat_x[31:0], quat_y[63:32], quat_z[95:64], quat_w[127:96]
// One beat per cycle unless stalled; the pipeline depth grows with the unrolled CORDIC steps.
// rst_n clears only the valid bits. A stall freezes the whole pipeline while the
// output register is full and not taken.
`timescale 1ns / 1ps
module euler_angles_to_quaternion
  import eaq_pkg::*;
#(
  parameter int CORDIC_STEPS = 24,
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // pitch_deg, yaw_deg, roll_deg
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // quat_x, quat_y, quat_z, quat_w
);
  localparam int LAT = CORDIC_STEPS + 5;
  localparam int DEPTH = LAT + 6;

  logic en;
  logic [DEPTH-1:0] vld_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
  end

  logic signed [31:0] sp, cp, sy, cy, sr, cr;
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_p (
    .clk(clk), .en(en), .angle(in_tdata[23:0]), .sin_q(sp), .cos_q(cp));
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_y (
    .clk(clk), .en(en), .angle(in_tdata[47:24]), .sin_q(sy), .cos_q(cy));
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_r (
    .clk(clk), .en(en), .angle(in_tdata[71:48]), .sin_q(sr), .cos_q(cr));

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return 32'(t);
  endfunction

  function automatic logic signed [31:0] fin(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] lim;
    lim = 35'sd1 <<< OUT_FRAC_BITS;
    if (OUT_FRAC_BITS == 30) t = 35'(v);
    else t = (35'(v) + (35'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
    if (t > lim) t = lim;
    else if (t < -lim) t = -lim;
    return 32'(t);
  endfunction

  // pairwise products: spcy, cpsy, cpcy, spsy
  logic signed [63:0] p_r [4];
  logic signed [31:0] pr_r [4];
  logic signed [31:0] c1_r, s1_r, c2_r, s2_r;
  logic signed [63:0] t_r [8];
  logic signed [31:0] tr_r [8];
  logic signed [33:0] sum_r [4];
  logic signed [31:0] q_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 64'(sp) * 64'(cy);
      p_r[1] <= 64'(cp) * 64'(sy);
      p_r[2] <= 64'(cp) * 64'(cy);
      p_r[3] <= 64'(sp) * 64'(sy);
      c1_r <= cr; s1_r <= sr;
      for (int k = 0; k < 4; k++) pr_r[k] <= rnd30(p_r[k]);
      c2_r <= c1_r; s2_r <= s1_r;
      t_r[0] <= 64'(pr_r[0]) * 64'(c2_r);
      t_r[1] <= 64'(pr_r[1]) * 64'(s2_r);
      t_r[2] <= 64'(pr_r[1]) * 64'(c2_r);
      t_r[3] <= 64'(pr_r[0]) * 64'(s2_r);
      t_r[4] <= 64'(pr_r[2]) * 64'(s2_r);
      t_r[5] <= 64'(pr_r[3]) * 64'(c2_r);
      t_r[6] <= 64'(pr_r[2]) * 64'(c2_r);
      t_r[7] <= 64'(pr_r[3]) * 64'(s2_r);
      for (int k = 0; k < 8; k++) tr_r[k] <= rnd30(t_r[k]);
      sum_r[0] <= 34'(tr_r[0]) - 34'(tr_r[1]);
      sum_r[1] <= 34'(tr_r[2]) + 34'(tr_r[3]);
      sum_r[2] <= 34'(tr_r[4]) - 34'(tr_r[5]);
      sum_r[3] <= 34'(tr_r[6]) + 34'(tr_r[7]);
      for (int k = 0; k < 4; k++) q_r[k] <= fin(sum_r[k]);
    end
  end

  assign out_tdata = {q_r[3], q_r[2], q_r[1], q_r[0]};

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready mismatch");
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(q_r[0]) <= (32'sd1 <<< OUT_FRAC_BITS)
                 && $signed(q_r[0]) >= -(32'sd1 <<< OUT_FRAC_BITS)))
    else $error("x out of range");
`endif
endmodule
